// ===== sv/rif_pkg.sv =====
// Package for the recent-ID set: payload structs, cell control struct and codes.
// No dependencies; every module of the block imports it.

package rif_pkg;

    localparam int unsigned ID_W   = 32;
    localparam int unsigned HCNT_W = 5;
    localparam int unsigned CAP_W  = 5;

    // Item function codes
    localparam logic FUNC_MSG  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic            func;
        logic [ID_W-1:0] ident;
    } in_item_t;

    typedef struct packed {
        logic              hit;
        logic              evicted_valid;
        logic [ID_W-1:0]   evicted_ident;
        logic [HCNT_W-1:0] held_count;
        logic [ID_W-1:0]   list_ident;
        logic              is_empty;
        logic              last;
    } out_item_t;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic shift;   // take the left neighbour's ID (insert at the front)
        logic rotate;  // take the right neighbour's ID, tail takes the head
    } cell_ctrl_t;

endpackage

// ===== sv/recent_id_fifo_set_top.sv =====
// Top level of the recent-ID set: chain of rif_cell, count, read-out sequencer.
// Depends on rif_pkg and rif_cell.
//
// Usage:
//   s_valid/s_ready/s_data take one item per transfer. func = FUNC_MSG checks
//   ident against the held IDs; on a miss it enters at the front and the
//   oldest drops off once capacity is reached. func = FUNC_READ lists the held
//   IDs front first, one result per ID, last set on the final one; an empty
//   set gives one result with is_empty set.
//   m_valid/m_ready/m_data carry results through a single output register.
//   cfg_we/cfg_wdata write the capacity (0 acts as 1, above DEPTH as DEPTH);
//   write it only while the block is idle.
// Timing:
//   A message's result is valid the cycle after the transfer, and a new
//   message can be taken every cycle while the receiver keeps up. A read-out
//   of n IDs rotates the chain one step per result, and no item is taken
//   until the last result has been loaded.
//   The per-cell compare and one-step shift set the message rate.
// Reset:
//   Clears the count, capacity returns to 16; no clearing pass is needed.
//   A stalled receiver holds the output register and stops all progress.

module recent_id_fifo_set_top
    import rif_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CAP_W-1:0] cap_reg;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    logic             slot_free;
    logic             in_xfer;
    logic [CNT_W-1:0] eff_cap;
    logic [CW-1:0]    cap_wide;
    logic             any_hit;
    logic             full;
    logic [CNT_W-1:0] tail_pos;
    cell_ctrl_t       ctrl;

    logic [ID_W-1:0]  cell_ident [DEPTH];
    logic [DEPTH-1:0] cell_match;

    // Chain of cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [ID_W-1:0] left_w;
        logic [ID_W-1:0] right_w;
        if (i == 0) begin : g_head
            assign left_w = s_data.ident;
        end else begin : g_body
            assign left_w = cell_ident[i-1];
        end
        if (i == DEPTH - 1) begin : g_end
            assign right_w = cell_ident[0];
        end else begin : g_mid
            assign right_w = cell_ident[i+1];
        end
        rif_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .in_use      (CNT_W'(i) < cnt_reg),
            .at_tail     (CNT_W'(i) == tail_pos),
            .probe_ident (s_data.ident),
            .left_ident  (left_w),
            .right_ident (right_w),
            .head_ident  (cell_ident[0]),
            .ident       (cell_ident[i]),
            .match       (cell_match[i])
        );
    end

    // Clamp the capacity register to 1..DEPTH
    assign cap_wide = CW'(cap_reg);
    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CNT_W'(1);
        end else if (cap_wide > CW'(DEPTH)) begin
            eff_cap = CNT_W'(DEPTH);
        end else begin
            eff_cap = CNT_W'(cap_reg);
        end
    end

    assign tail_pos  = cnt_reg - CNT_W'(1);
    assign any_hit   = |cell_match;
    assign full      = cnt_reg >= eff_cap;
    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && slot_free;
    assign in_xfer   = s_valid && s_ready;

    // Sequence messages and read-out
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ctrl         = '0;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next.last = 1'b1;
                    if (s_data.func == FUNC_MSG) begin
                        m_data_next.hit = any_hit;
                        if (!any_hit) begin
                            ctrl.shift = 1'b1;
                            if (full) begin
                                m_data_next.evicted_valid = 1'b1;
                                m_data_next.evicted_ident = cell_ident[tail_pos[IDX_W-1:0]];
                            end else begin
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        m_data_next.held_count = HCNT_W'(any_hit || full ? cnt_reg
                                                          : cnt_reg + CNT_W'(1));
                    end else if (cnt_reg == '0) begin
                        m_data_next.is_empty = 1'b1;
                    end else begin
                        // first result is loaded by the read-out state
                        m_valid_next = m_valid_reg && !m_ready;
                        m_data_next  = m_data_reg;
                        pos_next     = '0;
                        state_next   = ST_READ;
                    end
                end
            end
            ST_READ: begin
                // Emit the head and rotate the chain by one place
                if (slot_free) begin
                    ctrl.rotate            = 1'b1;
                    m_valid_next           = 1'b1;
                    m_data_next            = '0;
                    m_data_next.list_ident = cell_ident[0];
                    m_data_next.held_count = HCNT_W'(cnt_reg);
                    m_data_next.last       = (pos_reg == tail_pos);
                    pos_next               = pos_reg + CNT_W'(1);
                    if (pos_reg == tail_pos) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            pos_reg     <= '0;
            cap_reg     <= CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // Hold the result payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Read-out only runs over a non-empty set, within the held entries
    a_read_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (cnt_reg != '0) && (pos_reg < cnt_reg))
        else $error("read-out over an empty or overrun set");

    // The count never exceeds the chain length
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("held count beyond chain length");

    // The count only ever grows by one
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (cnt_reg != $past(cnt_reg)))
        |-> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("held count changed by more than one");

    // A message transfer yields a result in the next cycle
    a_msg_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && (s_data.func == FUNC_MSG)) |=> (m_valid_reg && m_data_reg.last))
        else $error("message gave no result");

endmodule

// ===== sv/rif_cell.sv =====
// One cell of the ID chain: holds a single ID and compares it with the probe.
// Depends on rif_pkg.

module rif_cell
    import rif_pkg::*;
(
    input  logic            aclk,
    input  cell_ctrl_t      ctrl,
    input  logic            in_use,
    input  logic            at_tail,
    input  logic [ID_W-1:0] probe_ident,
    input  logic [ID_W-1:0] left_ident,
    input  logic [ID_W-1:0] right_ident,
    input  logic [ID_W-1:0] head_ident,
    output logic [ID_W-1:0] ident,
    output logic            match
);

    logic [ID_W-1:0] ident_reg;
    logic [ID_W-1:0] ident_next;

    // Select the next held ID: shift down on insert, rotate up on read-out
    always_comb begin
        ident_next = ident_reg;
        if (ctrl.shift) begin
            ident_next = left_ident;
        end else if (ctrl.rotate) begin
            ident_next = at_tail ? head_ident : right_ident;
        end
    end

    always_ff @(posedge aclk) begin
        ident_reg <= ident_next;
    end

    // Compare only while this place holds a live entry
    assign match = in_use && (ident_reg == probe_ident);
    assign ident = ident_reg;

endmodule
